// ===== sv/afsc_pkg.sv =====
// Shared types and constants of the approach free-space check block.
// No dependencies; every other file imports this package.
package afsc_pkg;

  localparam int unsigned MAP_WIDTH_DEF     = 256;
  localparam int unsigned MAP_HEIGHT_DEF    = 256;
  localparam int unsigned MAX_OBSTACLES_DEF = 1024;

  // beat codes
  localparam logic [1:0] CMD_WRITE_CELL = 2'd0;
  localparam logic [1:0] CMD_CLEAR_OBST = 2'd1;
  localparam logic [1:0] CMD_ADD_OBST   = 2'd2;
  localparam logic [1:0] CMD_QUERY      = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_WIN_W     = 3'd1;
  localparam logic [2:0] REG_WIN_H     = 3'd2;
  localparam logic [2:0] REG_LIMIT     = 3'd3;
  localparam logic [2:0] REG_ORIGIN_X  = 3'd4;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd5;
  localparam logic [2:0] REG_CELL_SIZE = 3'd6;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 24;

  // divider: numerator 2*(p-o) +/- window, denominator 2*cell_size
  localparam int unsigned NUM_W = 20;
  localparam int unsigned DEN_W = 11;

  localparam logic [16:0] COUNT_SAT = 17'h1FFFF;

  typedef struct packed {
    logic       in_ready;
    logic       clr_run;
    logic       scan_run;
    logic       div_start;
    logic       bound_wr;
    logic [1:0] div_sel;
    logic       cnt_start;
    logic       cnt_run;
    logic       load_out;
  } afsc_cmd_t;

  typedef struct packed {
    logic query_acc;
    logic clr_done;
    logic scan_hit;
    logic scan_done;
    logic div_done;
    logic cnt_done;
    logic out_full;
  } afsc_sts_t;

endpackage

// ===== sv/afsc_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on afsc_pkg for operand widths.
module afsc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [afsc_pkg::NUM_W-1:0] dividend_i,
  input  logic [afsc_pkg::DEN_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [afsc_pkg::NUM_W-1:0] quo_o,
  output logic [afsc_pkg::DEN_W-1:0] rem_o
);
  import afsc_pkg::*;

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W-1:0]  rem_q, den_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;
  logic [DEN_W:0]    trial;

  assign trial = {rem_q, quo_q[NUM_W-1]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(NUM_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      if (!trial[DEN_W]) begin
        rem_q <= trial[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DEN_W-2:0], quo_q[NUM_W-1]};
        quo_q <= {quo_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/afsc_datapath.sv =====
// Datapath: config registers, unknown-cell map, obstacle list, scan, bounds, count.
// Depends on afsc_pkg and afsc_div.
module afsc_datapath #(
  parameter int unsigned MAP_WIDTH     = afsc_pkg::MAP_WIDTH_DEF,
  parameter int unsigned MAP_HEIGHT    = afsc_pkg::MAP_HEIGHT_DEF,
  parameter int unsigned MAX_OBSTACLES = afsc_pkg::MAX_OBSTACLES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  afsc_pkg::afsc_cmd_t             cmd_i,
  output afsc_pkg::afsc_sts_t             sts_o,
  input  logic                            cfg_we_i,
  input  logic [afsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [afsc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic [afsc_pkg::IN_DATA_W-1:0]  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [afsc_pkg::OUT_DATA_W-1:0] out_data_o
);
  import afsc_pkg::*;

  localparam int unsigned CELLS  = MAP_WIDTH * MAP_HEIGHT;
  localparam int unsigned MAP_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned XW     = (MAP_WIDTH > 1) ? $clog2(MAP_WIDTH) : 1;
  localparam int unsigned YW     = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1;
  localparam int unsigned OBS_AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int unsigned OBS_CW = $clog2(MAX_OBSTACLES + 1);
  localparam int unsigned CNT_W  = $clog2(CELLS + 1);
  localparam int unsigned BW     = NUM_W + 2;

  // ---------------- input fields ----------------
  logic [1:0]         in_cmd;
  logic [15:0]        in_idx;
  logic               in_mark;
  logic signed [16:0] in_x, in_y;
  logic               in_acc;

  assign in_cmd  = in_data_i[1:0];
  assign in_idx  = in_data_i[17:2];
  assign in_mark = in_data_i[18];
  assign in_x    = in_data_i[35:19];
  assign in_y    = in_data_i[52:36];
  assign in_acc  = in_valid_i && cmd_i.in_ready;

  // ---------------- configuration ----------------
  logic [15:0]        thr_q, win_w_q, win_h_q;
  logic [16:0]        limit_q;
  logic signed [16:0] org_x_q, org_y_q;
  logic [9:0]         cs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= 16'd100;
      win_w_q <= 16'd800;
      win_h_q <= 16'd800;
      limit_q <= 17'd10;
      org_x_q <= '0;
      org_y_q <= '0;
      cs_q    <= 10'd50;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THRESHOLD: thr_q   <= cfg_wdata_i[15:0];
        REG_WIN_W:     win_w_q <= cfg_wdata_i[15:0];
        REG_WIN_H:     win_h_q <= cfg_wdata_i[15:0];
        REG_LIMIT:     limit_q <= cfg_wdata_i;
        REG_ORIGIN_X:  org_x_q <= cfg_wdata_i;
        REG_ORIGIN_Y:  org_y_q <= cfg_wdata_i;
        REG_CELL_SIZE: cs_q    <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  // ---------------- query point ----------------
  logic signed [16:0] qx_q, qy_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && in_cmd == CMD_QUERY) begin
      qx_q <= in_x;
      qy_q <= in_y;
    end
  end

  // ---------------- obstacle list ----------------
  logic [33:0]       obs_mem [MAX_OBSTACLES];
  logic [33:0]       obs_rd_q;
  logic [OBS_CW-1:0] obs_cnt_q, k_q;
  logic              obs_we, obs_re, v1_q, hit_q;

  assign obs_we = in_acc && in_cmd == CMD_ADD_OBST && 32'(obs_cnt_q) < 32'(MAX_OBSTACLES);
  assign obs_re = cmd_i.scan_run && k_q < obs_cnt_q && !hit_q;

  always_ff @(posedge clk_i) begin
    if (obs_we) obs_mem[obs_cnt_q[OBS_AW-1:0]] <= {in_y, in_x};
    if (obs_re) obs_rd_q <= obs_mem[k_q[OBS_AW-1:0]];
  end

  logic signed [17:0] ddx, ddy;
  logic [17:0]        adx, ady;
  logic               near;

  assign ddx  = {obs_rd_q[16], obs_rd_q[16:0]} - {qx_q[16], qx_q};
  assign ddy  = {obs_rd_q[33], obs_rd_q[33:17]} - {qy_q[16], qy_q};
  assign adx  = ddx[17] ? 18'(-ddx) : 18'(ddx);
  assign ady  = ddy[17] ? 18'(-ddy) : 18'(ddy);
  assign near = adx < {2'b00, thr_q} && ady < {2'b00, thr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obs_cnt_q <= '0;
      k_q       <= '0;
      v1_q      <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      if (in_acc && in_cmd == CMD_CLEAR_OBST) obs_cnt_q <= '0;
      else if (obs_we) obs_cnt_q <= obs_cnt_q + 1'b1;
      if (in_acc && in_cmd == CMD_QUERY) begin
        k_q   <= '0;
        v1_q  <= 1'b0;
        hit_q <= 1'b0;
      end else begin
        v1_q <= obs_re;
        if (obs_re) k_q <= k_q + 1'b1;
        if (v1_q && near) hit_q <= 1'b1;
      end
    end
  end

  // ---------------- window bounds ----------------
  logic signed [17:0]      dx, dy, dsel;
  logic [15:0]             wsel;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        num_mag;
  logic [DEN_W-1:0]        den;
  logic                    num_neg_q, div_done;
  logic [NUM_W-1:0]        quo;
  logic [DEN_W-1:0]        rem;

  assign dx   = {qx_q[16], qx_q} - {org_x_q[16], org_x_q};
  assign dy   = {qy_q[16], qy_q} - {org_y_q[16], org_y_q};
  assign dsel = cmd_i.div_sel[1] ? dy : dx;
  assign wsel = cmd_i.div_sel[1] ? win_h_q : win_w_q;
  // even selects take the low edge (minus half window), odd the high edge
  assign num  = cmd_i.div_sel[0] ? {dsel[17], dsel, 1'b0} + {4'b0000, wsel}
                                 : {dsel[17], dsel, 1'b0} - {4'b0000, wsel};
  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign den     = (cs_q == '0) ? DEN_W'(2) : {cs_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) num_neg_q <= num[NUM_W-1];
  end

  afsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_mag),
    .divisor_i  (den),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  // floor rounds a negative inexact quotient away from zero, ceil a positive one
  logic                 adj;
  logic [BW-1:0]        bmag;
  logic signed [BW-1:0] bnd, lim_sel;
  logic                 is_y, is_hi;

  assign is_y    = cmd_i.div_sel[1];
  assign is_hi   = cmd_i.div_sel[0];
  assign adj     = (rem != '0) && (num_neg_q ? !is_hi : is_hi);
  assign bmag    = {2'b00, quo} + BW'(adj);
  assign bnd     = num_neg_q ? BW'(-bmag) : BW'(bmag);
  assign lim_sel = is_y ? BW'(MAP_HEIGHT - 1) : BW'(MAP_WIDTH - 1);

  logic [XW-1:0] xlo_q, xhi_q, ci_q;
  logic [YW-1:0] ylo_q, yhi_q, cj_q;
  logic          empty_q;
  logic [BW-1:0] bclamp;

  always_comb begin
    if (!is_hi) bclamp = bnd[BW-1] ? '0 : bnd;
    else        bclamp = (bnd > lim_sel) ? lim_sel : bnd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bound_wr) begin
      unique case (cmd_i.div_sel)
        2'd0:    xlo_q <= XW'(bclamp);
        2'd1:    xhi_q <= XW'(bclamp);
        2'd2:    ylo_q <= YW'(bclamp);
        default: yhi_q <= YW'(bclamp);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= 1'b0;
    end else if (in_acc && in_cmd == CMD_QUERY) begin
      empty_q <= 1'b0;
    end else if (cmd_i.bound_wr) begin
      if (!is_hi && bnd > lim_sel) empty_q <= 1'b1;
      if (is_hi && bnd[BW-1])      empty_q <= 1'b1;
    end
  end

  // ---------------- unknown map ----------------
  logic              map_mem [CELLS];
  logic [MAP_AW-1:0] clr_addr_q, base_q, rd_addr, wr_addr;
  logic              map_we, map_wd, map_re, map_rd_q;
  logic              cell_wr;

  assign cell_wr = in_acc && in_cmd == CMD_WRITE_CELL && 32'(in_idx) < 32'(CELLS);
  assign map_we  = cmd_i.clr_run || cell_wr;
  assign wr_addr = cmd_i.clr_run ? clr_addr_q : MAP_AW'(in_idx);
  assign map_wd  = cmd_i.clr_run ? 1'b0 : in_mark;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)              clr_addr_q <= '0;
    else if (cmd_i.clr_run)   clr_addr_q <= clr_addr_q + 1'b1;
  end

  // ---------------- window count ----------------
  logic             fin_q, rv_q;
  logic [CNT_W-1:0] acc_q;

  assign map_re  = cmd_i.cnt_run && !fin_q;
  assign rd_addr = base_q + MAP_AW'(ci_q);

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[wr_addr] <= map_wd;
    if (map_re) map_rd_q <= map_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= 1'b1;
      rv_q  <= 1'b0;
      acc_q <= '0;
    end else if (cmd_i.cnt_start) begin
      fin_q <= empty_q || xlo_q > xhi_q || ylo_q > yhi_q;
      rv_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      rv_q <= map_re;
      if (rv_q) acc_q <= acc_q + CNT_W'(map_rd_q);
      if (map_re && ci_q == xhi_q && cj_q == yhi_q) fin_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_start) begin
      ci_q   <= xlo_q;
      cj_q   <= ylo_q;
      base_q <= MAP_AW'(ylo_q * MAP_WIDTH);
    end else if (map_re) begin
      if (ci_q == xhi_q) begin
        ci_q   <= xlo_q;
        cj_q   <= cj_q + 1'b1;
        base_q <= base_q + MAP_AW'(MAP_WIDTH);
      end else begin
        ci_q <= ci_q + 1'b1;
      end
    end
  end

  // ---------------- result register ----------------
  logic        out_valid_q, out_free_q, out_hit_q;
  logic [16:0] out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)             out_valid_q <= 1'b0;
    else if (cmd_i.load_out) out_valid_q <= 1'b1;
    else if (out_ready_i)    out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_hit_q  <= hit_q;
      out_free_q <= !hit_q && !(32'(acc_q) > 32'(limit_q));
      if (hit_q)                      out_cnt_q <= '0;
      else if (32'(acc_q) > 32'(COUNT_SAT)) out_cnt_q <= COUNT_SAT;
      else                            out_cnt_q <= 17'(acc_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {5'b00000, out_cnt_q, out_hit_q, out_free_q};

  // ---------------- status ----------------
  assign sts_o.query_acc = in_acc && in_cmd == CMD_QUERY;
  assign sts_o.clr_done  = 32'(clr_addr_q) == 32'(CELLS - 1);
  assign sts_o.scan_hit  = hit_q;
  assign sts_o.scan_done = !hit_q && !v1_q && !(k_q < obs_cnt_q);
  assign sts_o.div_done  = div_done;
  assign sts_o.cnt_done  = fin_q && !rv_q;
  assign sts_o.out_full  = out_valid_q && !out_ready_i;

endmodule

// ===== sv/afsc_ctrl.sv =====
// Controller state machine: map clearing, obstacle scan, bound divides, count, result.
// Depends on afsc_pkg.
module afsc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  afsc_pkg::afsc_sts_t sts_i,
  output afsc_pkg::afsc_cmd_t cmd_o
);
  import afsc_pkg::*;

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_DIV_GO   = 3'd3;
  localparam logic [2:0] ST_DIV_WAIT = 3'd4;
  localparam logic [2:0] ST_CNT_GO   = 3'd5;
  localparam logic [2:0] ST_CNT      = 3'd6;
  localparam logic [2:0] ST_DONE     = 3'd7;

  logic [2:0] state_q, state_d;
  logic [1:0] sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.div_sel = sel_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_run = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.query_acc) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = ST_DONE;
        end else if (sts_i.scan_done) begin
          sel_d   = '0;
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.bound_wr = 1'b1;
          sel_d   = sel_q + 1'b1;
          state_d = (sel_q == 2'd3) ? ST_CNT_GO : ST_DIV_GO;
        end
      end
      ST_CNT_GO: begin
        cmd_o.cnt_start = 1'b1;
        state_d = ST_CNT;
      end
      ST_CNT: begin
        cmd_o.cnt_run = 1'b1;
        if (sts_i.cnt_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!sts_i.out_full) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/approach_free_space_check_core.sv =====
// Top level of the approach free-space check block.
// Depends on afsc_pkg, afsc_ctrl, afsc_datapath (which holds afsc_div).
//
//  channel   direction  beat carries
//  s_axis    in         cmd, cell_index, cell_unknown, point_x, point_y
//  m_axis    out        is_free, hit_obstacle, unknown_count (queries only)
//  cfg       in         register index and write data, no handshake
//
// Cell writes and obstacle list commands are applied as they are accepted.
// A query scans its N obstacles one per cycle (stopping early on a hit), runs
// four 20-step divides for the window edges, then does one map read per cell of
// the clamped R x C window.
// After reset every map cell is swept to known, with s_axis_tready low.
// A stalled result holds the next query at its end only.
module approach_free_space_check_core #(
  parameter int unsigned MAP_WIDTH     = afsc_pkg::MAP_WIDTH_DEF,
  parameter int unsigned MAP_HEIGHT    = afsc_pkg::MAP_HEIGHT_DEF,
  parameter int unsigned MAX_OBSTACLES = afsc_pkg::MAX_OBSTACLES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [1:0] cmd, [17:2] cell_index, [18] cell_unknown, [35:19] point_x, [52:36] point_y
  input  logic [afsc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] is_free, [1] hit_obstacle, [18:2] unknown_count
  output logic [afsc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [afsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [afsc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import afsc_pkg::*;

  afsc_cmd_t cmd;
  afsc_sts_t sts;

  afsc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  afsc_datapath #(
    .MAP_WIDTH     (MAP_WIDTH),
    .MAP_HEIGHT    (MAP_HEIGHT),
    .MAX_OBSTACLES (MAX_OBSTACLES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  assign s_axis_tready = cmd.in_ready;

endmodule

// ===== sv/afsc_checker.sv =====
// Port-level checks of approach_free_space_check_core, bound to the top level.
// Depends on afsc_pkg.
module afsc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [afsc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [afsc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import afsc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_hit_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0] && m_axis_tdata[18:2] == '0)
    else $error("obstacle hit with free flag or nonzero count");

  a_busy_after_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |->
      $past(s_axis_tvalid && s_axis_tdata[1:0] == CMD_QUERY))
    else $error("input stalled without a query beat");

endmodule

bind approach_free_space_check_core afsc_checker u_afsc_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for approach_free_space_check_core.
// Needs afsc_pkg and the core RTL. It predicts every query result from its own
// copy of the cell map, the obstacle list and the registers.
`timescale 1ns / 1ps

module tb;
  import afsc_pkg::*;

  localparam int MAP_W      = 256;
  localparam int MAP_H      = 256;
  localparam int OBST_MAX   = 1024;
  localparam int STALL_LIMIT = 300000;
  localparam int N_PHASES   = 5;

  typedef struct {
    logic [1:0]         cmd;
    logic [15:0]        idx;
    logic               mark;
    logic signed [16:0] px;
    logic signed [16:0] py;
  } beat_t;

  typedef struct {
    logic        free;
    logic        hit;
    logic [16:0] cnt;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  approach_free_space_check_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  // map/obstacle/register mirror
  bit          unk_map [MAP_W*MAP_H];
  int          obs_x [OBST_MAX];
  int          obs_y [OBST_MAX];
  int          obs_n;
  int          thr, win_w, win_h, lim, org_x, org_y, csz;

  beat_t       pending_q [$];
  verdict_t    verdict_q [$];
  int          issued, accepted, n_query, n_hit, n_free, errors;
  bit          no_idle;
  bit          s_acc;
  int          s_gap, m_gap, quiet;

  function automatic longint div_floor(longint n, longint d);
    longint q = n / d;
    if (n % d != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint div_ceil(longint n, longint d);
    longint q = n / d;
    if (n % d != 0 && n > 0) q++;
    return q;
  endfunction

  function automatic verdict_t check_point(int x, int y);
    verdict_t v;
    longint c2, i1, i2, j1, j2, cnt;
    v.free = 1'b0;
    v.hit = 1'b1;
    v.cnt = '0;
    for (int k = 0; k < obs_n; k++) begin
      if ((x > obs_x[k] ? x - obs_x[k] : obs_x[k] - x) < thr &&
          (y > obs_y[k] ? y - obs_y[k] : obs_y[k] - y) < thr)
        return v;
    end
    c2 = 2 * ((csz == 0) ? 1 : csz);
    i1 = div_floor(2 * longint'(x - org_x) - win_w, c2);
    i2 = div_ceil(2 * longint'(x - org_x) + win_w, c2);
    j1 = div_floor(2 * longint'(y - org_y) - win_h, c2);
    j2 = div_ceil(2 * longint'(y - org_y) + win_h, c2);
    if (i1 < 0) i1 = 0;
    if (j1 < 0) j1 = 0;
    if (i2 > MAP_W - 1) i2 = MAP_W - 1;
    if (j2 > MAP_H - 1) j2 = MAP_H - 1;
    cnt = 0;
    for (longint i = i1; i <= i2; i++)
      for (longint j = j1; j <= j2; j++)
        cnt += unk_map[j * MAP_W + i];
    v.hit = 1'b0;
    v.free = (cnt > lim) ? 1'b0 : 1'b1;
    v.cnt = (cnt > 131071) ? 17'h1FFFF : cnt[16:0];
    return v;
  endfunction

  // apply an accepted beat to the mirror, queue the expected verdict of a query
  task automatic absorb_beat(beat_t b);
    case (b.cmd)
      CMD_WRITE_CELL: unk_map[b.idx] = b.mark;
      CMD_CLEAR_OBST: obs_n = 0;
      CMD_ADD_OBST: begin
        if (obs_n < OBST_MAX) begin
          obs_x[obs_n] = b.px;
          obs_y[obs_n] = b.py;
          obs_n++;
        end
      end
      default: begin
        verdict_q = {verdict_q, check_point(b.px, b.py)};
      end
    endcase
  endtask

  // driver: new beat at the falling edge once the last one was taken
  always @(negedge clk_i) begin
    if (s_axis_tvalid && !s_acc) begin
      // hold the beat
    end else if (s_gap > 0) begin
      s_gap <= s_gap - 1;
      s_axis_tvalid <= 1'b0;
    end else if (pending_q.size() > 0) begin
      beat_t b;
      b = pending_q.pop_front();
      s_axis_tdata <= {3'b0, b.py, b.px, b.mark, b.idx, b.cmd};
      s_axis_tvalid <= 1'b1;
      if (!no_idle && $urandom_range(4) == 0) s_gap <= $urandom_range(11, 1);
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (m_gap > 0) begin
      m_gap <= m_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(5) == 0) begin
      m_gap <= $urandom_range(10, 0);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor and predictor, both at the rising edge
  always @(posedge clk_i) begin
    s_acc <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      beat_t b;
      b.cmd  = s_axis_tdata[1:0];
      b.idx  = s_axis_tdata[17:2];
      b.mark = s_axis_tdata[18];
      b.px   = s_axis_tdata[35:19];
      b.py   = s_axis_tdata[52:36];
      absorb_beat(b);
      accepted++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result beat with none expected: %h", $time, m_axis_tdata);
        errors++;
      end else begin
        verdict_t v;
        v = verdict_q.pop_front();
        n_query++;
        if (v.hit) n_hit++;
        if (v.free) n_free++;
        if (m_axis_tdata[0] !== v.free || m_axis_tdata[1] !== v.hit ||
            m_axis_tdata[18:2] !== v.cnt) begin
          $display("%0t: mismatch exp free=%0b hit=%0b cnt=%0d got free=%0b hit=%0b cnt=%0d",
                   $time, v.free, v.hit, v.cnt,
                   m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[18:2]);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles in a row without any beat moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet);
      $display("approach_free_space_check_core regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push(logic [1:0] cmd, int idx, bit mark, int x, int y);
    beat_t b;
    b.cmd = cmd;
    b.idx = idx[15:0];
    b.mark = mark;
    b.px = x[16:0];
    b.py = y[16:0];
    pending_q = {pending_q, b};
    issued++;
  endtask

  task automatic drain();
    while (issued != accepted || verdict_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val[16:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_THRESHOLD: thr = val & 'hFFFF;
      REG_WIN_W:     win_w = val & 'hFFFF;
      REG_WIN_H:     win_h = val & 'hFFFF;
      REG_LIMIT:     lim = val & 'h1FFFF;
      REG_ORIGIN_X:  org_x = val;
      REG_ORIGIN_Y:  org_y = val;
      default:       csz = val & 'h3FF;
    endcase
  endtask

  function automatic int clamp17(int v);
    if (v < -65536) return -65536;
    if (v > 65535) return 65535;
    return v;
  endfunction

  // threshold, width, height, limit, origin x, origin y, cell size
  int cfg_tab [N_PHASES][7] = '{
    '{100,   800,   800,   10,    0,      0,      50},
    '{0,     0,     0,     0,     -65536, -65536, 1000},
    '{65535, 65535, 65535, 65536, 0,      0,      1000},
    '{300,   40,    30,    3,     65535,  -1000,  0},
    '{200,   600,   400,   20,    -3000,  2000,   37}
  };

  initial begin
    int c, fx, fy, x, y, r;
    thr = 100; win_w = 800; win_h = 800; lim = 10;
    org_x = 0; org_y = 0; csz = 50; obs_n = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: map corners, threshold edges, input extremes
    push(CMD_WRITE_CELL, 0, 1, 0, 0);
    push(CMD_WRITE_CELL, 65535, 1, -65536, 65535);
    for (int k = 0; k < 6; k++) push(CMD_WRITE_CELL, 20 * MAP_W + 18 + k, 1, 0, 0);
    push(CMD_QUERY, 1000, 1, 0, 0);
    push(CMD_QUERY, 0, 0, 0, 0);
    push(CMD_ADD_OBST, 0, 0, 1000, 1000);
    push(CMD_QUERY, 1000, 1, 0, 0);
    push(CMD_QUERY, 0, 0, 1100, 1050);  // exactly on threshold: no hit
    push(CMD_QUERY, 0, 0, 1099, 901);
    push(CMD_QUERY, 0, 0, 65535, 65535);
    push(CMD_QUERY, 0, 0, -65536, -65536);
    push(CMD_CLEAR_OBST, 0, 0, 0, 0);
    push(CMD_QUERY, 0, 0, 1000, 1000);
    push(CMD_QUERY, 0, 0, 12775, 12775);
    push(CMD_WRITE_CELL, 65535, 0, 65535, -65536);
    push(CMD_QUERY, 0, 0, 12775, 12775);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      if (p == N_PHASES - 1) no_idle = 1;
      for (int k = 0; k < 7; k++) write_reg(k[2:0], cfg_tab[p][k]);
      c = (csz == 0) ? 1 : csz;
      fx = $urandom_range(250, 5);
      fy = $urandom_range(250, 5);
      for (int n = 0; n < 80; n++) begin
        if (n == 40) drain();  // sender holds until every result is back
        r = $urandom_range(99);
        x = clamp17(org_x + fx * c + int'($urandom_range(8 * c)) - 4 * c);
        y = clamp17(org_y + fy * c + int'($urandom_range(8 * c)) - 4 * c);
        if (r < 35) begin
          push(CMD_WRITE_CELL, (fy + int'($urandom_range(12)) - 6) * MAP_W +
               fx + int'($urandom_range(12)) - 6, $urandom_range(3) != 0, x, y);
        end else if (r < 40) begin
          push(CMD_CLEAR_OBST, $urandom, 1'($urandom), x, y);
        end else if (r < 58) begin
          push(CMD_ADD_OBST, $urandom, 1'($urandom),
               clamp17(x + int'($urandom_range(6 * c))), y);
        end else if (r < 63) begin
          push(CMD_QUERY, $urandom, 1'($urandom), int'($urandom) % 65536,
               int'($urandom) % 65536);
        end else begin
          push(CMD_QUERY, $urandom, 1'($urandom), x, y);
        end
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    $display("%0d beats sent, %0d queries checked over %0d register settings",
             accepted, n_query, N_PHASES);
    $display("  %0d blocked by an obstacle, %0d free", n_hit, n_free);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("approach_free_space_check_core regression: pass");
    end else begin
      $display("approach_free_space_check_core regression: fail");
    end
    $finish;
  end

endmodule
